>>> rtl/pnf_pkg.sv
package pnf_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int COORD_W    = 16;
  localparam int CHAN_W     = 8;
  localparam int PERM_W     = 8;
  localparam int PERM_DEPTH = 256;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FREQ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_AMP  = 1'b1;

  localparam logic [CFG_W-1:0] FREQ_RESET = 16'd1311;
  localparam logic [CFG_W-1:0] AMP_RESET  = 16'd0;

  typedef logic [CHAN_W-1:0]  chan_t;
  typedef logic [PERM_W-1:0]  perm_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [CFG_W-1:0]   cfg_data_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

endpackage

>>> rtl/pnf_if.sv
interface pnf_in_if;
  logic            valid;
  logic            ready;
  logic            command;
  pnf_pkg::perm_t  table_index;
  pnf_pkg::perm_t  table_value;
  pnf_pkg::coord_t pixel_x;
  pnf_pkg::coord_t pixel_y;
  pnf_pkg::chan_t  red_in;
  pnf_pkg::chan_t  green_in;
  pnf_pkg::chan_t  blue_in;

  modport source (output valid, command, table_index, table_value, pixel_x, pixel_y,
                  red_in, green_in, blue_in, input ready);
  modport sink (input valid, command, table_index, table_value, pixel_x, pixel_y,
                red_in, green_in, blue_in, output ready);
endinterface

interface pnf_out_if;
  logic           valid;
  logic           ready;
  pnf_pkg::chan_t red_out;
  pnf_pkg::chan_t green_out;
  pnf_pkg::chan_t blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

interface pnf_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [pnf_pkg::CFG_IDX_W-1:0]      index;
  pnf_pkg::cfg_data_t                 data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/pnf_ram.sv
module pnf_ram #(
  parameter int DEPTH = pnf_pkg::PERM_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  pnf_pkg::perm_t           wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output pnf_pkg::perm_t           rdata0,
  output pnf_pkg::perm_t           rdata1
);

  pnf_pkg::perm_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-first: a write on the same edge is seen by the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

>>> rtl/pnf_fade.sv
module pnf_fade #(
  parameter int FRAC_BITS = pnf_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS-1:0] t,
  output logic [FRAC_BITS:0]   fade
);

  localparam int F  = FRAC_BITS;
  localparam int QW = F + 6;

  logic [F-1:0]       t_d;
  logic [F-1:0]       t2;
  logic [F-1:0]       t3;
  logic [F+3:0]       q;
  logic [2*F-1:0]     sq;
  logic [2*F-1:0]     cube;
  logic [2*F+3:0]     prod;
  logic signed [QW-1:0] q_raw;

  assign sq    = t * t;
  assign cube  = t2 * t_d;
  assign q_raw = QW'(6) * $signed({{(QW-F){1'b0}}, t2})
               - QW'(15) * $signed({{(QW-F){1'b0}}, t_d})
               + $signed(QW'(10) <<< F);
  assign prod  = t3 * q;

  always_ff @(posedge clk) begin
    if (en) begin
      t_d  <= t;
      t2   <= sq[2*F-1:F];
      t3   <= cube[2*F-1:F];
      q    <= q_raw[QW-1] ? '0 : q_raw[F+3:0];
      fade <= prod[2*F:F];
    end
  end

endmodule

>>> rtl/perlin_noise_pixel_filter.sv
// Perlin noise pixel filter. One item per clock while the output is not stalled, pixels
// and table loads alike. Load items (command 0) write one permutation entry as they
// pass stage 2 and produce no result; load every entry before sending pixels. The
// permutation table is held twice: a 256-entry copy read at x and x+1, and an even/odd
// banked copy read at the four corner hashes, so each hash level needs only one read.
// When the output register holds an untaken result the whole pipeline stalls. Write
// noise_frequency and noise_amplitude only while idle.
module perlin_noise_pixel_filter #(
  parameter int COORD_BITS = pnf_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = pnf_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  pnf_in_if.sink       pix_in,
  pnf_out_if.source    pix_out,
  pnf_cfg_if.sink      cfg
);

  localparam int CW    = pnf_pkg::COORD_W;
  localparam int PB    = pnf_pkg::PERM_W;
  localparam int F     = FRAC_BITS;
  localparam int UP    = (F >= 16) ? F - 16 : 0;
  localparam int DOWN  = (F >= 16) ? 0 : 16 - F;
  localparam int PW    = 2 * CW + UP;
  localparam int GW    = F + 3;
  localparam int DW    = F + 4;
  localparam int MW    = 2 * F + 6;
  localparam int AMW   = GW + pnf_pkg::CFG_W + 1;
  localparam int DLW   = pnf_pkg::CHAN_W + 3;
  localparam int SW    = pnf_pkg::CHAN_W + 4;
  localparam int HALF  = pnf_pkg::PERM_DEPTH / 2;
  localparam int HAW   = $clog2(HALF);
  localparam logic [CW-1:0] CMASK =
    (COORD_BITS >= CW) ? {CW{1'b1}} : CW'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic signed [GW-1:0] ONE_Q = GW'(64'd1 << F);

  function automatic logic signed [GW-1:0] grad(input logic [1:0] h,
                                                input logic signed [GW-1:0] x,
                                                input logic signed [GW-1:0] y);
    case (h)
      2'd0:    grad = x + y;
      2'd1:    grad = y - x;
      2'd2:    grad = x - y;
      default: grad = -x - y;
    endcase
  endfunction

  function automatic logic signed [GW-1:0] lerp(input logic signed [GW-1:0] a,
                                                input logic signed [GW-1:0] b,
                                                input logic [F:0] w);
    logic signed [DW-1:0] d;
    logic signed [MW-1:0] p;
    d = DW'(b) - DW'(a);
    p = $signed({1'b0, w}) * d;
    // truncate toward zero
    p = p + (p[MW-1] ? MW'((64'd1 << F) - 64'd1) : MW'(0));
    p = p >>> F;
    lerp = a + GW'(p);
  endfunction

  function automatic pnf_pkg::chan_t add_clamp(input pnf_pkg::chan_t c,
                                               input logic signed [DLW-1:0] dl);
    logic signed [SW-1:0] s;
    s = $signed({{(SW-pnf_pkg::CHAN_W){1'b0}}, c}) + SW'(dl);
    if (s[SW-1]) begin
      add_clamp = '0;
    end else if (s > SW'(255)) begin
      add_clamp = '1;
    end else begin
      add_clamp = s[pnf_pkg::CHAN_W-1:0];
    end
  endfunction

  pnf_pkg::cfg_data_t freq;
  pnf_pkg::cfg_data_t amp;

  logic adv;
  logic v1, v2, v3, v4, v5, v6, v7, ov;

  logic              cmd1;
  pnf_pkg::perm_t    idx1, val1;
  logic [2*CW-1:0]   px1, py1;
  pnf_pkg::rgb_t     rgb1, rgb2, rgb3, rgb4, rgb5, rgb6, rgb7;

  logic [PW-1:0]     sx, sy;
  pnf_pkg::perm_t    xi1, yi1;

  pnf_pkg::perm_t    yi2;
  logic [F-1:0]      xf2, yf2, xf3, yf3;
  logic              sel0, sel2;

  logic signed [GW-1:0] ga, gb, gc, gd;
  logic signed [GW-1:0] x1, x2, n6;
  logic [F:0]           u4, v4f, v5f;
  logic signed [DLW-1:0] delta7;
  logic signed [AMW-1:0] dprod;

  pnf_pkg::perm_t ha, hb;
  pnf_pkg::perm_t s0, s1, s2, s3;
  pnf_pkg::perm_t ev0, ev1, od0, od1;
  pnf_pkg::perm_t haa, hab, hba, hbb;
  logic we1, we_ev, we_od;
  logic signed [GW-1:0] xa, xb, ya, yb;

  assign adv          = !ov || pix_out.ready;
  assign pix_in.ready = adv && !rst;
  assign cfg.ready    = !rst;
  assign pix_out.valid = ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      freq <= pnf_pkg::FREQ_RESET;
      amp  <= pnf_pkg::AMP_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        pnf_pkg::REG_FREQ: freq <= cfg.data;
        pnf_pkg::REG_AMP:  amp  <= cfg.data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, ov} <= '0;
    end else if (adv) begin
      v1 <= pix_in.valid;
      v2 <= v1 && (cmd1 == pnf_pkg::CMD_PIXEL);
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      ov <= v7;
    end
  end

  // stage 1: scale coordinates
  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1 <= pix_in.command;
      idx1 <= pix_in.table_index;
      val1 <= pix_in.table_value;
      px1  <= (pix_in.pixel_x & CMASK) * freq;
      py1  <= (pix_in.pixel_y & CMASK) * freq;
      rgb1 <= '{pix_in.red_in, pix_in.green_in, pix_in.blue_in};
    end
  end

  assign sx  = (PW'(px1) << UP) >> DOWN;
  assign sy  = (PW'(py1) << UP) >> DOWN;
  assign xi1 = sx[F+PB-1:F];
  assign yi1 = sy[F+PB-1:F];

  // stage 2: first hash level, loads write here
  assign we1   = adv && v1 && (cmd1 == pnf_pkg::CMD_LOAD);
  assign we_ev = we1 && !idx1[0];
  assign we_od = we1 && idx1[0];

  pnf_ram #(.DEPTH(pnf_pkg::PERM_DEPTH)) u_perm (
    .clk, .we(we1), .waddr(idx1), .wdata(val1), .re(adv),
    .raddr0(xi1), .raddr1(xi1 + 8'd1), .rdata0(ha), .rdata1(hb)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      yi2  <= yi1;
      xf2  <= sx[F-1:0];
      yf2  <= sy[F-1:0];
      rgb2 <= rgb1;
    end
  end

  pnf_fade #(.FRAC_BITS(F)) u_fade_x (.clk, .en(adv), .t(sx[F-1:0]), .fade(u4));
  pnf_fade #(.FRAC_BITS(F)) u_fade_y (.clk, .en(adv), .t(sy[F-1:0]), .fade(v4f));

  // stage 3: corner hashes from the banked copy
  assign s0 = ha + yi2;
  assign s1 = s0 + 8'd1;
  assign s2 = hb + yi2;
  assign s3 = s2 + 8'd1;

  pnf_ram #(.DEPTH(HALF)) u_perm_even (
    .clk, .we(we_ev), .waddr(idx1[PB-1:1]), .wdata(val1), .re(adv),
    .raddr0(s0[0] ? s1[PB-1:1] : s0[PB-1:1]),
    .raddr1(s2[0] ? s3[PB-1:1] : s2[PB-1:1]),
    .rdata0(ev0), .rdata1(ev1)
  );

  pnf_ram #(.DEPTH(HALF)) u_perm_odd (
    .clk, .we(we_od), .waddr(idx1[PB-1:1]), .wdata(val1), .re(adv),
    .raddr0(s0[0] ? s0[PB-1:1] : s1[PB-1:1]),
    .raddr1(s2[0] ? s2[PB-1:1] : s3[PB-1:1]),
    .rdata0(od0), .rdata1(od1)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      xf3  <= xf2;
      yf3  <= yf2;
      sel0 <= s0[0];
      sel2 <= s2[0];
      rgb3 <= rgb2;
    end
  end

  // stage 4: gradients
  assign haa = sel0 ? od0 : ev0;
  assign hab = sel0 ? ev0 : od0;
  assign hba = sel2 ? od1 : ev1;
  assign hbb = sel2 ? ev1 : od1;
  assign xa  = $signed({3'b000, xf3});
  assign ya  = $signed({3'b000, yf3});
  assign xb  = xa - ONE_Q;
  assign yb  = ya - ONE_Q;

  always_ff @(posedge clk) begin
    if (adv) begin
      ga   <= grad(haa[1:0], xa, ya);
      gb   <= grad(hba[1:0], xb, ya);
      gc   <= grad(hab[1:0], xa, yb);
      gd   <= grad(hbb[1:0], xb, yb);
      rgb4 <= rgb3;
    end
  end

  // stages 5 to 7: interpolation and amplitude
  assign dprod = n6 * $signed({1'b0, amp});

  always_ff @(posedge clk) begin
    if (adv) begin
      x1     <= lerp(ga, gb, u4);
      x2     <= lerp(gc, gd, u4);
      v5f    <= v4f;
      rgb5   <= rgb4;
      n6     <= lerp(x1, x2, v5f);
      rgb6   <= rgb5;
      delta7 <= DLW'((dprod + (dprod[AMW-1] ? AMW'((64'd1 << (F + 8)) - 64'd1)
                                            : AMW'(0))) >>> (F + 8));
      rgb7   <= rgb6;
    end
  end

  // stage 8: output register
  always_ff @(posedge clk) begin
    if (adv) begin
      pix_out.red_out   <= add_clamp(rgb7.red, delta7);
      pix_out.green_out <= add_clamp(rgb7.green, delta7);
      pix_out.blue_out  <= add_clamp(rgb7.blue, delta7);
    end
  end

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (adv && v1 && cmd1 == pnf_pkg::CMD_LOAD) |=> !v2)
    else $error("load item entered the noise pipeline");

  a_zero_amp: assert property (@(posedge clk) disable iff (rst)
    (adv && v6 && amp == '0) |=> (delta7 == '0))
    else $error("nonzero delta with zero amplitude");

  a_fade_range: assert property (@(posedge clk) disable iff (rst)
    (v4 && !(u4 > (F+1)'(64'd1 << F))) || !v4)
    else $error("fade weight above one");

endmodule

>>> verif/pnf_tb_if.sv
// Channel interfaces used by the testbench are the RTL ones (rtl/pnf_if.sv).
// This file only holds the item type shared by the stimulus code.
package pnf_tb_pkg;
  import pnf_pkg::*;

  typedef struct {
    logic   command;
    perm_t  table_index;
    perm_t  table_value;
    coord_t pixel_x;
    coord_t pixel_y;
    chan_t  red_in;
    chan_t  green_in;
    chan_t  blue_in;
  } pix_item_t;
endpackage

>>> verif/tb_perlin_noise_pixel_filter.sv
module tb_perlin_noise_pixel_filter;
  import pnf_pkg::*;
  import pnf_tb_pkg::*;

  localparam int FB = 16;
  localparam longint ONE = 64'sd1 << FB;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pnf_in_if  pin ();
  pnf_out_if pout ();
  pnf_cfg_if pcfg ();

  perlin_noise_pixel_filter u_dut (
    .clk(clk), .rst(rst), .pix_in(pin.sink), .pix_out(pout.source), .cfg(pcfg.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  perm_t     perm_mirror [PERM_DEPTH];
  cfg_data_t freq_q;
  cfg_data_t amp_q;
  rgb_t      rgb_expected [$];
  int        errors = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  bit        hold_off = 1'b0;

  function automatic longint mul_tz(longint a, longint b, int sh);
    longint ma, mb, m;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m = (ma * mb) >>> sh;
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic longint fade_curve(longint t);
    longint t2, t3, q;
    t2 = mul_tz(t, t, FB);
    t3 = mul_tz(t2, t, FB);
    q = 6 * t2 - 15 * t + 10 * ONE;
    if (q < 0) q = 0;
    return mul_tz(t3, q, FB);
  endfunction

  function automatic longint corner_grad(perm_t h, longint x, longint y);
    case (h[1:0])
      2'd0: return x + y;
      2'd1: return -x + y;
      2'd2: return x - y;
      default: return -x - y;
    endcase
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    return a + mul_tz(t, b - a, FB);
  endfunction

  function automatic chan_t sat_add(chan_t c, longint d);
    longint v;
    v = longint'(c) + d;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return chan_t'(v);
  endfunction

  function automatic rgb_t noisy_pixel(pix_item_t it);
    longint px, py, xf, yf, u, v, x1, x2, n, d;
    perm_t xi, yi, a, b, aa, ab, ba, bb;
    rgb_t r;
    px = longint'(it.pixel_x) * longint'(freq_q);
    py = longint'(it.pixel_y) * longint'(freq_q);
    xi = perm_t'(px >> FB);
    yi = perm_t'(py >> FB);
    xf = px & (ONE - 1);
    yf = py & (ONE - 1);
    a  = perm_mirror[xi];
    b  = perm_mirror[perm_t'(xi + 8'd1)];
    aa = perm_mirror[perm_t'(a + yi)];
    ab = perm_mirror[perm_t'(a + yi + 8'd1)];
    ba = perm_mirror[perm_t'(b + yi)];
    bb = perm_mirror[perm_t'(b + yi + 8'd1)];
    u = fade_curve(xf);
    v = fade_curve(yf);
    x1 = blend(corner_grad(aa, xf, yf), corner_grad(ba, xf - ONE, yf), u);
    x2 = blend(corner_grad(ab, xf, yf - ONE), corner_grad(bb, xf - ONE, yf - ONE), u);
    n = blend(x1, x2, v);
    d = mul_tz(n, longint'(amp_q), FB + 8);
    r.red   = sat_add(it.red_in, d);
    r.green = sat_add(it.green_in, d);
    r.blue  = sat_add(it.blue_in, d);
    return r;
  endfunction

  // valid stays up between back-to-back items; this task drops it only while idling
  task automatic send_item(pix_item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      pin.valid <= 1'b0;
      @(negedge clk);
    end
    pin.valid       <= 1'b1;
    pin.command     <= it.command;
    pin.table_index <= it.table_index;
    pin.table_value <= it.table_value;
    pin.pixel_x     <= it.pixel_x;
    pin.pixel_y     <= it.pixel_y;
    pin.red_in      <= it.red_in;
    pin.green_in    <= it.green_in;
    pin.blue_in     <= it.blue_in;
    do @(posedge clk); while (!pin.ready);
    if (it.command == CMD_LOAD) perm_mirror[it.table_index] = it.table_value;
    else rgb_expected.push_back(noisy_pixel(it));
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, cfg_data_t val);
    pcfg.valid <= 1'b1;
    pcfg.index <= idx;
    pcfg.data  <= val;
    do @(posedge clk); while (!pcfg.ready);
    if (idx == REG_FREQ) freq_q = val;
    else amp_q = val;
    @(negedge clk);
    pcfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    pin.valid <= 1'b0;
    while (rgb_expected.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  function automatic pix_item_t load_item(perm_t idx, perm_t val);
    pix_item_t it;
    it = '{default: '0};
    it.command = CMD_LOAD;
    it.table_index = idx;
    it.table_value = val;
    return it;
  endfunction

  function automatic pix_item_t pixel_item(coord_t x, coord_t y, chan_t r, chan_t g, chan_t b);
    pix_item_t it;
    it = '{default: '0};
    it.command = CMD_PIXEL;
    it.pixel_x = x;
    it.pixel_y = y;
    it.red_in = r;
    it.green_in = g;
    it.blue_in = b;
    return it;
  endfunction

  task automatic load_shuffle();
    perm_t p [PERM_DEPTH];
    int j;
    perm_t tmp;
    for (int i = 0; i < PERM_DEPTH; i++) p[i] = perm_t'(i);
    for (int i = PERM_DEPTH - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = p[i]; p[i] = p[j]; p[j] = tmp;
    end
    for (int i = 0; i < PERM_DEPTH; i++) send_item(load_item(perm_t'(i), p[i]));
  endtask

  // receiver: checks against oldest expectation
  always @(posedge clk) begin
    if (!rst && pout.valid && pout.ready) begin
      if (rgb_expected.size() == 0) begin
        $error("unexpected pixel out: %0d %0d %0d", pout.red_out, pout.green_out,
               pout.blue_out);
        errors++;
      end else begin
        rgb_t e;
        e = rgb_expected.pop_front();
        if (pout.red_out !== e.red) begin
          $error("red_out expected %0d actual %0d", e.red, pout.red_out); errors++;
        end
        if (pout.green_out !== e.green) begin
          $error("green_out expected %0d actual %0d", e.green, pout.green_out); errors++;
        end
        if (pout.blue_out !== e.blue) begin
          $error("blue_out expected %0d actual %0d", e.blue, pout.blue_out); errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off) pout.ready <= 1'b0;
    else pout.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  typedef struct {
    pix_item_t it;
    bit        has_rgb;
    rgb_t      rgb;
  } vector_row_t;

  initial begin
    vector_row_t vectors [$];
    pin.valid = 1'b0; pin.command = CMD_LOAD; pin.table_index = '0; pin.table_value = '0;
    pin.pixel_x = '0; pin.pixel_y = '0; pin.red_in = '0; pin.green_in = '0;
    pin.blue_in = '0;
    pout.ready = 1'b0;
    pcfg.valid = 1'b0; pcfg.index = REG_FREQ; pcfg.data = '0;
    freq_q = FREQ_RESET;
    amp_q = AMP_RESET;
    foreach (perm_mirror[i]) perm_mirror[i] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // shuffled table first, then checks at reset settings (amplitude zero)
    load_shuffle();
    vectors.push_back('{pixel_item(16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00), 1,
                        '{8'h00, 8'h00, 8'h00}});
    vectors.push_back('{pixel_item(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF), 1,
                        '{8'hFF, 8'hFF, 8'hFF}});
    vectors.push_back('{pixel_item(16'h1234, 16'hABCD, 8'h55, 8'hAA, 8'h01), 1,
                        '{8'h55, 8'hAA, 8'h01}});
    foreach (vectors[i]) begin
      send_item(vectors[i].it);
      if (vectors[i].has_rgb) rgb_expected[rgb_expected.size() - 1] = vectors[i].rgb;
    end
    drain();

    // extremes of both registers
    write_reg(REG_AMP, 16'd32768);
    write_reg(REG_FREQ, 16'hFFFF);
    vectors.delete();
    vectors.push_back('{pixel_item(16'h0000, 16'h0000, 8'h80, 8'h00, 8'hFF), 0, '{0, 0, 0}});
    vectors.push_back('{pixel_item(16'hFFFF, 16'h0000, 8'h00, 8'hFF, 8'h80), 0, '{0, 0, 0}});
    vectors.push_back('{pixel_item(16'h0000, 16'hFFFF, 8'h10, 8'hF0, 8'h7F), 0, '{0, 0, 0}});
    vectors.push_back('{pixel_item(16'h8001, 16'h7FFF, 8'h00, 8'h00, 8'h00), 0, '{0, 0, 0}});
    vectors.push_back('{load_item(8'hFF, 8'h00), 0, '{0, 0, 0}});
    vectors.push_back('{load_item(8'h00, 8'hFF), 0, '{0, 0, 0}});
    vectors.push_back('{pixel_item(16'h00FF, 16'hFF00, 8'hFF, 8'hFF, 8'hFF), 0, '{0, 0, 0}});
    vectors.push_back('{pixel_item(16'h0001, 16'h0003, 8'h01, 8'hFE, 8'h80), 0, '{0, 0, 0}});
    foreach (vectors[i]) send_item(vectors[i].it);
    drain();
    write_reg(REG_FREQ, 16'd0);
    write_reg(REG_AMP, 16'hFFFF);
    send_item(pixel_item(16'hFFFF, 16'hFFFF, 8'h80, 8'h00, 8'hFF));
    drain();

    // random part, three idling phases, different settings each
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 88 : 0;
      recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 8 : 0;
      drain();
      write_reg(REG_FREQ, cfg_data_t'($urandom_range(65535)));
      write_reg(REG_AMP, (ph == 2) ? cfg_data_t'($urandom_range(65535))
                                   : cfg_data_t'($urandom_range(32768)));
      for (int n = 0; n < 110; n++) begin
        if ($urandom_range(19) == 0) begin
          send_item(load_item(perm_t'($urandom), perm_t'($urandom)));
        end else begin
          send_item(pixel_item(coord_t'($urandom), coord_t'($urandom),
                               chan_t'($urandom), chan_t'($urandom), chan_t'($urandom)));
        end
        // long stall of the receiver while the sender keeps going
        if (ph == 2 && n == 50) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (60) @(posedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
      end
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pin.valid <= 1'b0;
    while (rgb_expected.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && rgb_expected.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
